@@ rtl/ctmp_pkg.sv @@
// Shared types and constants for the coordinated trapezoid move planner.
// No dependencies; imported by ctmp_alu and the top level.
`timescale 1ns / 1ps
package ctmp_pkg;

  localparam int unsigned MAX_AXES = 8;
  localparam int unsigned IDX_W    = $clog2(MAX_AXES);
  localparam int unsigned CNT_W    = $clog2(MAX_AXES + 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUSY     = 2'd1;
  localparam logic [1:0] STATUS_NO_TIME  = 2'd2;
  localparam logic [1:0] STATUS_NO_ROOT  = 2'd3;

  localparam logic [15:0] TOL_RESET = 16'd66;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic               axis_busy;
    logic [31:0]        accel;
    logic [31:0]        max_velocity;
    logic signed [31:0] start_position;
    logic signed [31:0] target_position;
    logic               last_axis;
  } ctmp_in_t;

  typedef struct packed {
    logic [2:0]  axis_index;
    logic [31:0] new_max_velocity;
    logic [39:0] move_time;
    logic [1:0]  status;
    logic        last_result;
  } ctmp_out_t;

endpackage

@@ rtl/ctmp_alu.sv @@
// Shared bit-serial arithmetic unit: 64x64 multiply, 128/64 divide, 128-bit isqrt.
// Depends on ctmp_pkg.
`timescale 1ns / 1ps
module ctmp_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctmp_pkg::alu_req_t req_i,
  input  logic [127:0]      opa_i,
  input  logic [63:0]       opb_i,
  output logic              done_o,
  output logic [127:0]      res_o
);
  import ctmp_pkg::*;

  logic          busy_q;
  logic          done_q;
  alu_op_e       op_q;
  logic [7:0]    cnt_q;
  logic [127:0]  work_q;
  logic [127:0]  shf_q;
  logic [66:0]   rem_q;
  logic [63:0]   dvs_q;

  logic [64:0]   div_t;
  logic          div_ge;
  logic [66:0]   sq_t;
  logic [66:0]   sq_trial;
  logic          sq_ge;

  assign div_t    = {rem_q[63:0], shf_q[127]};
  assign div_ge   = div_t >= {1'b0, dvs_q};
  assign sq_t     = {rem_q[64:0], shf_q[127:126]};
  assign sq_trial = {1'b0, work_q[63:0], 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      work_q <= '0;
      shf_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          op_q   <= req_i.op;
          rem_q  <= '0;
          work_q <= '0;
          dvs_q  <= opb_i;
          case (req_i.op)
            OP_MUL: begin
              shf_q <= {64'd0, opa_i[63:0]};
              cnt_q <= 8'd64;
            end
            OP_DIV: begin
              shf_q <= opa_i;
              cnt_q <= 8'd128;
            end
            default: begin
              shf_q <= opa_i;
              cnt_q <= 8'd64;
            end
          endcase
        end
      end else begin
        case (op_q)
          OP_MUL: begin
            if (dvs_q[0]) work_q <= work_q + shf_q;
            shf_q <= {shf_q[126:0], 1'b0};
            dvs_q <= {1'b0, dvs_q[63:1]};
          end
          OP_DIV: begin
            rem_q <= {3'd0, div_ge ? (div_t[63:0] - dvs_q) : div_t[63:0]};
            shf_q <= {shf_q[126:0], div_ge};
          end
          default: begin
            rem_q  <= sq_ge ? (sq_t - sq_trial) : sq_t;
            work_q <= {64'd0, work_q[62:0], sq_ge};
            shf_q  <= {shf_q[125:0], 2'b00};
          end
        endcase
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = work_q;
      OP_DIV:  res_o = shf_q;
      default: res_o = {64'd0, work_q[63:0]};
    endcase
  end

endmodule

@@ rtl/coordinated_trapezoid_move_planner.sv @@
// Coordinated trapezoid move planner: loads axes, plans a time-synchronized move.
// Depends on ctmp_pkg and ctmp_alu.
// A non-last item is only stored. The last item runs the plan on one shared
// bit-serial unit (multiply, divide, isqrt): a time pass over every axis, then
// a re-solve of each axis whose time is below the longest; results then
// stream one per cycle. Results cannot be stalled. Reset is async, active low.
`timescale 1ns / 1ps
module coordinated_trapezoid_move_planner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item channel
  input  logic                 start,
  output logic                 busy,
  input  ctmp_pkg::ctmp_in_t   item_i,
  // result channel
  output logic                 result_valid_o,
  output ctmp_pkg::ctmp_out_t  result_o,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ctmp_pkg::*;

  localparam logic [39:0] TIME_SAT = 40'hFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SPAN, ST_ENTRY, ST_DA, ST_VV, ST_VA, ST_TDIV, ST_RDIV, ST_SQRT,
    ST_TDONE, ST_SCHK, ST_PA, ST_PP, ST_SDA, ST_SSQRT, ST_ROOT, ST_EMIT
  } state_e;

  function automatic logic [39:0] sat40(input logic [127:0] x);
    sat40 = (x[127:40] != '0) ? TIME_SAT : x[39:0];
  endfunction

  // axis stores, written on load, by the time pass and by the velocity solve
  logic [31:0] acc_mem [MAX_AXES];
  logic [31:0] vel_mem [MAX_AXES];
  logic [31:0] sta_mem [MAX_AXES];
  logic [31:0] tgt_mem [MAX_AXES];
  logic [39:0] tim_mem [MAX_AXES];

  state_e      state_q;
  logic [15:0] tol_q;
  logic [CNT_W-1:0] cnt_q, n_q, i_q;
  logic        bseen_q;
  logic        ph_q;      // 0: time pass, 1: solve pass
  logic        go_q;      // shared unit request issued
  logic        k_q;       // which root is under test
  logic [31:0] a_q, v_q, d_q;
  logic [63:0] da_q, vv_q, va_q, s_q;
  logic [55:0] p_q;
  logic [127:0] tmp_q;
  logic [39:0] tn_q, tmax_q;
  logic        rv_q;
  ctmp_out_t   res_q;

  // shared unit
  alu_req_t     u_req;
  logic [127:0] u_a;
  logic [63:0]  u_b;
  logic         u_done;
  logic [127:0] u_res;

  ctmp_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .opa_i  (u_a),
    .opb_i  (u_b),
    .done_o (u_done),
    .res_o  (u_res)
  );

  logic             accept, room, ld_we, vel_we, tim_we;
  logic [IDX_W-1:0] ix;
  logic [32:0]      diff;
  logic [31:0]      dabs;
  logic [64:0]      root;
  logic [39:0]      tdiff;
  logic [81:0]      sub;
  logic             calc;

  assign accept = start && !busy;
  assign room   = cnt_q < CNT_W'(MAX_AXES);
  assign ld_we  = accept && room;
  assign ix     = i_q[IDX_W-1:0];

  // span |target - start| of the selected axis
  assign diff = {tgt_mem[ix][31], tgt_mem[ix]} - {sta_mem[ix][31], sta_mem[ix]};
  assign dabs = diff[32] ? 32'(-diff) : diff[31:0];

  assign root  = k_q ? (({9'd0, p_q} + {1'b0, s_q}) >> 1)
                     : (({9'd0, p_q} - {1'b0, s_q}) >> 1);
  assign tdiff = (tn_q > tmax_q) ? (tn_q - tmax_q) : (tmax_q - tn_q);
  assign sub   = {u_res[63:0], 18'd0};

  assign vel_we = (state_q == ST_TDONE) && ph_q && (tdiff < {24'd0, tol_q});
  assign tim_we = (state_q == ST_TDONE) && !ph_q;

  always_comb begin
    calc = 1'b1;
    u_req.op = OP_MUL;
    u_a = '0;
    u_b = '0;
    case (state_q)
      ST_DA:    begin u_a = {96'd0, d_q}; u_b = {32'd0, a_q}; end
      ST_VV:    begin u_a = {96'd0, v_q}; u_b = {32'd0, v_q}; end
      ST_VA:    begin u_a = {96'd0, v_q}; u_b = {32'd0, a_q}; end
      ST_TDIV:  begin
        u_req.op = OP_DIV;
        u_a = {32'd0, da_q, 32'd0} + {48'd0, vv_q, 16'd0};
        u_b = va_q;
      end
      ST_RDIV:  begin
        u_req.op = OP_DIV;
        u_a = {48'd0, d_q, 48'd0};
        u_b = {32'd0, a_q};
      end
      ST_SQRT, ST_SSQRT: begin u_req.op = OP_SQRT; u_a = tmp_q; end
      ST_PA:    begin u_a = {96'd0, a_q}; u_b = {24'd0, tmax_q}; end
      ST_PP:    begin u_a = {72'd0, p_q}; u_b = {8'd0, p_q}; end
      ST_SDA:   begin u_a = {96'd0, d_q}; u_b = {32'd0, a_q}; end
      default:  calc = 1'b0;
    endcase
    u_req.start = calc && !go_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      acc_mem[cnt_q[IDX_W-1:0]] <= item_i.accel;
      vel_mem[cnt_q[IDX_W-1:0]] <= item_i.max_velocity;
      sta_mem[cnt_q[IDX_W-1:0]] <= item_i.start_position;
      tgt_mem[cnt_q[IDX_W-1:0]] <= item_i.target_position;
    end
    if (vel_we) vel_mem[ix] <= v_q;
    if (tim_we) tim_mem[ix] <= tn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tol_q   <= TOL_RESET;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      bseen_q <= 1'b0;
      ph_q    <= 1'b0;
      go_q    <= 1'b0;
      k_q     <= 1'b0;
      rv_q    <= 1'b0;
      res_q   <= '0;
      a_q <= '0; v_q <= '0; d_q <= '0;
      da_q <= '0; vv_q <= '0; va_q <= '0; s_q <= '0; p_q <= '0;
      tmp_q <= '0; tn_q <= '0; tmax_q <= '0;
    end else begin
      rv_q <= 1'b0;
      if (psel && penable && pwrite && !paddr[2]) tol_q <= pwdata[15:0];
      if (calc) begin
        if (!go_q) go_q <= 1'b1;
        else if (u_done) go_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (room) cnt_q <= cnt_q + 1'b1;
            bseen_q <= bseen_q | (room & item_i.axis_busy);
            if (item_i.last_axis) begin
              cnt_q   <= '0;
              bseen_q <= 1'b0;
              n_q     <= room ? cnt_q + 1'b1 : cnt_q;
              i_q     <= '0;
              tmax_q  <= '0;
              ph_q    <= 1'b0;
              if (bseen_q | (room & item_i.axis_busy)) begin
                rv_q  <= 1'b1;
                res_q <= '{3'd0, 32'd0, 40'd0, STATUS_BUSY, 1'b1};
              end else begin
                state_q <= ST_SPAN;
              end
            end
          end
        end

        ST_SPAN: begin
          d_q <= dabs;
          a_q <= acc_mem[ix];
          v_q <= vel_mem[ix];
          if (!ph_q) state_q <= ST_ENTRY;
          else if (dabs == '0) begin
            rv_q <= 1'b1;
            res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_ROOT, 1'b1};
            state_q <= ST_IDLE;
          end else state_q <= ST_PA;
        end

        // rest-to-rest time of (a_q, v_q, d_q)
        ST_ENTRY: begin
          if (d_q == '0) begin
            tn_q    <= '0;
            state_q <= ST_TDONE;
          end else if (a_q == '0 || v_q == '0) begin
            if (!ph_q) begin
              rv_q <= 1'b1;
              res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_TIME, 1'b1};
              state_q <= ST_IDLE;
            end else if (k_q) begin
              rv_q <= 1'b1;
              res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_ROOT, 1'b1};
              state_q <= ST_IDLE;
            end else begin
              k_q <= 1'b1;
              state_q <= ST_ROOT;
            end
          end else state_q <= ST_DA;
        end
        ST_DA: if (go_q && u_done) begin
          da_q <= u_res[63:0];
          state_q <= ST_VV;
        end
        ST_VV: if (go_q && u_done) begin
          vv_q <= u_res[63:0];
          // trapezoid when v*v <= d*a*2^16
          if ({16'd0, u_res[63:0]} <= {da_q, 16'd0}) state_q <= ST_VA;
          else state_q <= ST_RDIV;
        end
        ST_VA: if (go_q && u_done) begin
          va_q <= u_res[63:0];
          state_q <= ST_TDIV;
        end
        ST_TDIV: if (go_q && u_done) begin
          tn_q <= sat40(u_res);
          state_q <= ST_TDONE;
        end
        ST_RDIV: if (go_q && u_done) begin
          tmp_q <= u_res;
          state_q <= ST_SQRT;
        end
        ST_SQRT: if (go_q && u_done) begin
          tn_q <= sat40({63'd0, u_res[63:0], 1'b0});
          state_q <= ST_TDONE;
        end

        ST_TDONE: begin
          if (!ph_q) begin
            if (tn_q > tmax_q) tmax_q <= tn_q;
            if (i_q + 1'b1 == n_q) begin
              ph_q <= 1'b1;
              i_q  <= '0;
              state_q <= ST_SCHK;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= ST_SPAN;
            end
          end else if (vel_we) begin
            i_q <= i_q + 1'b1;
            state_q <= ST_SCHK;
          end else if (k_q) begin
            rv_q <= 1'b1;
            res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_ROOT, 1'b1};
            state_q <= ST_IDLE;
          end else begin
            k_q <= 1'b1;
            state_q <= ST_ROOT;
          end
        end

        // solve pass: axes shorter than the longest get a new velocity
        ST_SCHK: begin
          if (i_q == n_q) begin
            i_q <= '0;
            state_q <= ST_EMIT;
          end else if (tim_mem[ix] < tmax_q) state_q <= ST_SPAN;
          else i_q <= i_q + 1'b1;
        end
        ST_PA: if (go_q && u_done) begin
          p_q <= u_res[71:16];
          state_q <= ST_PP;
        end
        ST_PP: if (go_q && u_done) begin
          tmp_q <= u_res;
          state_q <= ST_SDA;
        end
        ST_SDA: if (go_q && u_done) begin
          if ({46'd0, sub} > tmp_q) begin
            rv_q <= 1'b1;
            res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_ROOT, 1'b1};
            state_q <= ST_IDLE;
          end else begin
            tmp_q <= tmp_q - {46'd0, sub};
            state_q <= ST_SSQRT;
          end
        end
        ST_SSQRT: if (go_q && u_done) begin
          s_q <= u_res[63:0];
          k_q <= 1'b0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root[64:32] != '0) begin
            if (k_q) begin
              rv_q <= 1'b1;
              res_q <= '{3'(i_q), 32'd0, 40'd0, STATUS_NO_ROOT, 1'b1};
              state_q <= ST_IDLE;
            end else k_q <= 1'b1;
          end else begin
            v_q <= root[31:0];
            state_q <= ST_ENTRY;
          end
        end

        ST_EMIT: begin
          rv_q  <= 1'b1;
          res_q <= '{3'(i_q), vel_mem[ix], tmax_q, STATUS_OK, (i_q + 1'b1 == n_q)};
          i_q   <= i_q + 1'b1;
          if (i_q + 1'b1 == n_q) state_q <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;
  assign pready         = 1'b1;
  assign prdata         = paddr[2] ? 32'd0 : {16'd0, tol_q};

endmodule

@@ verif/coordinated_trapezoid_move_planner_tb.sv @@
// Self-checking testbench for the coordinated trapezoid move planner.
// Depends on ctmp_pkg and the coordinated_trapezoid_move_planner top level.
`timescale 1ns / 1ps
module coordinated_trapezoid_move_planner_tb;
  import ctmp_pkg::*;

  localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [2:0]  ADDR_TOL = 3'd0;   // time_tolerance register

  // Plan predictor plus the queue of plans still owed by the block.
  class plan_board;
    logic [31:0] acc_q[MAX_AXES];
    logic [31:0] vel_q[MAX_AXES];
    logic [31:0] pos0_q[MAX_AXES];
    logic [31:0] pos1_q[MAX_AXES];
    logic [39:0] dur_q[MAX_AXES];
    int unsigned n_loaded;
    bit          any_busy;
    logic [15:0] tol;
    ctmp_out_t   owed[$];
    int unsigned errors;

    function new();
      n_loaded = 0;
      any_busy = 0;
      tol      = TOL_RESET;
      errors   = 0;
    endfunction

    static function logic [63:0] root_floor(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
    endfunction

    // Rest-to-rest duration; 0 means unsolvable.
    static function bit duration(logic [63:0] a, logic [63:0] v, logic [63:0] d,
                                 output logic [39:0] t);
      logic [127:0] q;
      t = '0;
      if (d == 0) return 1;
      if (a == 0 || v == 0) return 0;
      if ({64'd0, v * v} <= ({64'd0, d * a} << 16)) begin
        // trapezoid: cruise reached
        q = (({64'd0, d * a} << 32) + ({64'd0, v * v} << 16)) / {64'd0, v * a};
      end else begin
        // triangle: peak below the limit
        q = {64'd0, root_floor(({64'd0, d} << 48) / {64'd0, a}) << 1};
      end
      t = (q > {88'd0, TIME_MAX}) ? TIME_MAX : q[39:0];
      return 1;
    endfunction

    function bit stretch_velocity(logic [63:0] a, logic [63:0] d, logic [39:0] tgt,
                                  output logic [31:0] vout);
      logic [127:0] pa;
      logic [63:0]  p;
      logic [127:0] sq;
      logic [127:0] sub;
      logic [63:0]  s;
      logic [63:0]  r[2];
      logic [39:0]  tn;
      logic [39:0]  diff;
      vout = '0;
      if (d == 0) return 0;
      pa  = {64'd0, a} * {88'd0, tgt};
      p   = pa[79:16];
      sq  = {64'd0, p} * {64'd0, p};
      sub = {64'd0, d * a} << 18;
      if (sub > sq) return 0;
      s    = root_floor(sq - sub);
      r[0] = (p - s) >> 1;   // slower root first
      r[1] = (p + s) >> 1;
      for (int k = 0; k < 2; k++) begin
        if (r[k] > 64'hFFFF_FFFF) continue;
        if (!duration(a, r[k], d, tn)) continue;
        diff = tn > tgt ? tn - tgt : tgt - tn;
        if (diff < {24'd0, tol}) begin
          vout = r[k][31:0];
          return 1;
        end
      end
      return 0;
    endfunction

    function logic [63:0] travel(int unsigned i);
      logic signed [32:0] dd;
      dd = $signed({pos1_q[i][31], pos1_q[i]}) - $signed({pos0_q[i][31], pos0_q[i]});
      return dd < 0 ? {31'd0, -dd} : {31'd0, dd};
    endfunction

    function void owe(int unsigned idx, logic [31:0] v, logic [39:0] t,
                      logic [1:0] st, bit lst);
      ctmp_out_t r;
      r.axis_index       = idx[2:0];
      r.new_max_velocity = v;
      r.move_time        = t;
      r.status           = st;
      r.last_result      = lst;
      owed.push_back(r);
    endfunction

    // Called for every accepted item.
    function void note_item(ctmp_in_t it);
      int unsigned n;
      logic [39:0] tmax;
      logic [31:0] v;
      if (n_loaded < MAX_AXES) begin
        acc_q[n_loaded]  = it.accel;
        vel_q[n_loaded]  = it.max_velocity;
        pos0_q[n_loaded] = it.start_position;
        pos1_q[n_loaded] = it.target_position;
        any_busy |= it.axis_busy;
        n_loaded++;
      end
      if (!it.last_axis) return;
      n        = n_loaded;
      n_loaded = 0;
      if (any_busy) begin
        any_busy = 0;
        owe(0, '0, '0, STATUS_BUSY, 1);
        return;
      end
      tmax = '0;
      for (int unsigned i = 0; i < n; i++) begin
        if (!duration({32'd0, acc_q[i]}, {32'd0, vel_q[i]}, travel(i), dur_q[i])) begin
          owe(i, '0, '0, STATUS_NO_TIME, 1);
          return;
        end
        if (dur_q[i] > tmax) tmax = dur_q[i];
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (dur_q[i] < tmax) begin
          if (!stretch_velocity({32'd0, acc_q[i]}, travel(i), tmax, v)) begin
            owe(i, '0, '0, STATUS_NO_ROOT, 1);
            return;
          end
          vel_q[i] = v;
        end
      end
      for (int unsigned i = 0; i < n; i++) owe(i, vel_q[i], tmax, STATUS_OK, i + 1 == n);
    endfunction

    function void check_result(ctmp_out_t got);
      ctmp_out_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = owed.pop_front();
      if (got.axis_index !== exp_r.axis_index ||
          got.new_max_velocity !== exp_r.new_max_velocity ||
          got.move_time !== exp_r.move_time || got.status !== exp_r.status ||
          got.last_result !== exp_r.last_result) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  ctmp_in_t    item_i;
  logic        result_valid_o;
  ctmp_out_t   result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  plan_board   board;
  int unsigned sent;
  int unsigned idle_pct;

  coordinated_trapezoid_move_planner i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Results cannot be held off: every strobe is checked on the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_result(result_o);
  end

  // Hands one item over; start stays high on return so back-to-back items
  // need no extra edge. Each idle cycle is drawn with the idle percentage.
  task automatic send_axis(ctmp_in_t it);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < idle_pct);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
    sent++;
  endtask

  // Wait until every owed result is back and the block is quiet again.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TOL;
    pwdata  <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.tol = v;
  endtask

  function automatic ctmp_in_t make_axis(bit b, logic [31:0] a, logic [31:0] v,
                                         logic [31:0] p0, logic [31:0] p1, bit lst);
    ctmp_in_t it;
    it.axis_busy       = b;
    it.accel           = a;
    it.max_velocity    = v;
    it.start_position  = p0;
    it.target_position = p1;
    it.last_axis       = lst;
    return it;
  endfunction

  // Plausible axis: moderate accel and velocity, short or medium travel.
  function automatic ctmp_in_t sane_axis(bit lst);
    logic [31:0] p0;
    int          span;
    p0   = $urandom_range(32'h3FFF_FFFF, 0) - 32'h2000_0000;
    span = ($urandom_range(1, 0) != 0) ? $urandom_range(200, 0) : $urandom_range(200000, 0);
    if ($urandom_range(1, 0) != 0) span = -span;
    return make_axis(0, $urandom_range(32'h4_0000, 32'h40),
                     $urandom_range(32'h80_0000, 32'h8000), p0, p0 + span, lst);
  endfunction

  function automatic ctmp_in_t noise_axis(bit lst);
    return make_axis($urandom_range(9, 0) == 0, $urandom, $urandom, $urandom, $urandom, lst);
  endfunction

  task automatic random_set();
    int unsigned n;
    bit          clean;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 85)      n = $urandom_range(3, 1);
    else if (pick < 97) n = $urandom_range(8, 4);
    else                n = $urandom_range(10, 9);   // spills past a full set
    clean = $urandom_range(99, 0) < 85;
    for (int unsigned i = 0; i < n; i++) begin
      if (clean && $urandom_range(19, 0) != 0) send_axis(sane_axis(i + 1 == n));
      else send_axis(noise_axis(i + 1 == n));
    end
  endtask

  initial begin
    logic [15:0] tol_plan[6];
    board    = new();
    sent     = 0;
    idle_pct = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets at the reset tolerance.
    // busy axis at the end of a set
    send_axis(make_axis(0, 32'h1_0000, 32'h1_0000, 0, 100, 0));
    send_axis(make_axis(1, 32'h1_0000, 32'h1_0000, 0, 100, 1));
    // zero accel, then zero velocity
    send_axis(make_axis(0, 32'h0, 32'h1_0000, 0, 50, 1));
    send_axis(make_axis(0, 32'h1_0000, 32'h0, 5, -5, 1));
    // zero-length axis alone, then beside a moving one
    send_axis(make_axis(0, 32'h1_0000, 32'h1_0000, 7, 7, 1));
    send_axis(make_axis(0, 32'h2_0000, 32'h3_0000, 0, 1000, 0));
    send_axis(make_axis(0, 32'h1_0000, 32'h1_0000, 9, 9, 1));
    // field extremes: full travel, largest then smallest accel and velocity
    send_axis(make_axis(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_axis(make_axis(0, 32'h1, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    // equal axes keep their velocity; a triangle axis and a trapezoid axis
    send_axis(make_axis(0, 32'h1_0000, 32'h4_0000, 0, 5000, 0));
    send_axis(make_axis(0, 32'h1_0000, 32'h4_0000, 100, -4900, 0));
    send_axis(make_axis(0, 32'h8000, 32'h100_0000, 0, 300, 0));
    send_axis(make_axis(0, 32'h2_0000, 32'h1000, 0, 20, 1));
    // nine axes: the ninth is dropped, busy flag and all, but still closes
    for (int unsigned i = 0; i < 8; i++) send_axis(sane_axis(0));
    send_axis(make_axis(1, 32'h1_0000, 32'h1_0000, 0, 10, 1));
    drain();

    tol_plan[0] = 16'd0;
    tol_plan[1] = 16'hFFFF;
    tol_plan[2] = 16'($urandom_range(16'hFFFF, 0));
    tol_plan[3] = TOL_RESET;
    tol_plan[4] = 16'd1;
    tol_plan[5] = 16'($urandom_range(2000, 2));
    sent = 0;
    for (int unsigned ph = 0; ph < 6; ph++) begin
      write_tolerance(tol_plan[ph]);
      while (sent < (ph + 1) * 41) begin
        idle_pct = sent < 82 ? 29 : (sent < 164 ? 56 : 0);
        random_set();
      end
      drain();   // sender holds off until the block is empty
    end

    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
